@@ rtl/core/tat_pkg.sv @@
package tat_pkg;

  localparam int ALARM_SLOTS = 16;
  localparam int SLOT_W      = (ALARM_SLOTS > 1) ? $clog2(ALARM_SLOTS) : 1;

  localparam int TIME_W = 64;
  localparam int TASK_W = 8;
  localparam int DIVR_W = 16;

  // the ms dividend is tick_count * 1000, which needs ten more bits
  localparam int DIVD_W = TIME_W + 10;
  // divisor covers both 65536 and the tick rate (at most 1193182)
  localparam int DIVS_W = 21;
  localparam int CNT_W  = $clog2(DIVD_W + 1);

  localparam logic [DIVS_W-1:0] BASE_HZ     = 21'd1193182;
  localparam logic [DIVR_W-1:0] DIV_RESET   = 16'd1193;
  localparam logic [CNT_W-1:0]  STEPS_RATE  = CNT_W'(DIVS_W);
  localparam logic [CNT_W-1:0]  STEPS_TIME  = CNT_W'(DIVD_W);

  localparam logic OP_TICK  = 1'b0;
  localparam logic OP_SLEEP = 1'b1;

  typedef enum logic [1:0] {
    ST_ACCEPT = 2'd0,
    ST_FULL   = 2'd1,
    ST_WOKEN  = 2'd2
  } status_t;

  typedef struct packed {
    logic             start;
    logic [CNT_W-1:0] steps;
  } div_req_t;

endpackage

@@ rtl/core/tat_div.sv @@
module tat_div import tat_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  div_req_t          req,
  input  logic [DIVD_W-1:0] dividend,
  input  logic [DIVS_W-1:0] divisor,
  output logic              done,
  output logic [DIVD_W-1:0] quotient
);

  logic [DIVS_W-1:0] rem_r;
  logic [DIVD_W-1:0] quo_r;
  logic [DIVS_W-1:0] dvs_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              busy_r;
  logic              done_r;

  logic [DIVS_W:0]   trial;
  logic [DIVS_W:0]   diff;
  logic              ge;
  logic [DIVS_W-1:0] rem_nxt;
  logic [DIVD_W-1:0] quo_nxt;

  // restoring division, one quotient bit per cycle; dividend msb first
  always_comb begin
    trial   = {rem_r, quo_r[DIVD_W-1]};
    ge      = (trial >= {1'b0, dvs_r});
    diff    = trial - {1'b0, dvs_r};
    rem_nxt = ge ? diff[DIVS_W-1:0] : trial[DIVS_W-1:0];
    quo_nxt = {quo_r[DIVD_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= !req.start && busy_r && (cnt_r == CNT_W'(1));
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= req.steps;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= '0;
      quo_r <= dividend;
      dvs_r <= divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

@@ rtl/core/tick_alarm_table_unit.sv @@
// Tick counter with a table of sleep alarms. A beat with in_tuser = 0 is a timer tick: the
// count advances and every pending alarm that is due is reported as woken (status 2), in
// ascending slot order, with tlast on the final one; a tick that wakes nothing gives no beat.
// A beat with in_tuser = 1 is a sleep request and gives exactly one beat: status 0 with the
// start time when a slot was free, status 1 with the current time when the table is full.
// Time in ms is floor(1000 * ticks / floor(1193182 / divider)), saturated at 2^64-1, where a
// divider of 0 means 65536. Both divisions run on one shared restoring divider, one bit per
// cycle: 21 steps for the tick rate, then 74 for the time. A tick then reads and checks
// each table slot in turn and emits one beat per woken task; a stall on the result side
// holds any beat. in_tready is low while an item is being worked on. The user must write
// the divider register with cfg_wr_en only while idle; the block itself does not enforce it.
module tick_alarm_table_unit import tat_pkg::*; (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_wr_en,
  input  logic [DIVR_W-1:0]          cfg_wr_data,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [TIME_W+TASK_W-1:0]   in_tdata,   // sleep_ms, task_id
  input  logic                       in_tuser,   // operation
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [TASK_W+TIME_W-1:0]   out_tdata,  // task_number, time_ms
  output logic [1:0]                 out_tuser,  // status
  output logic                       out_tlast
);

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_RATE  = 9'b000000010,
    S_MUL   = 9'b000000100,
    S_TIME  = 9'b000001000,
    S_SAT   = 9'b000010000,
    S_SLEEP = 9'b000100000,
    S_RD    = 9'b001000000,
    S_CK    = 9'b010000000,
    S_EMIT  = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;

  logic [DIVR_W-1:0]      divider_r;
  logic [TIME_W-1:0]      tick_cnt_r;
  logic [TIME_W-1:0]      time_r;
  logic                   op_r;
  logic [TIME_W-1:0]      len_r;
  logic [TASK_W-1:0]      task_r;
  logic [ALARM_SLOTS-1:0] slot_valid_r;
  logic [ALARM_SLOTS-1:0] due_r;
  logic [SLOT_W-1:0]      idx_r;
  logic [TIME_W-1:0]      rd_start_r;
  logic [TIME_W-1:0]      rd_len_r;
  logic                   rd_vld_r;

  logic [TIME_W-1:0] alarm_start [ALARM_SLOTS];
  logic [TIME_W-1:0] alarm_len   [ALARM_SLOTS];
  logic [TASK_W-1:0] alarm_task  [ALARM_SLOTS];

  logic              out_valid_r;
  logic [1:0]        out_status_r;
  logic [TASK_W-1:0] out_task_r;
  logic [TIME_W-1:0] out_time_r;
  logic              out_last_r;

  div_req_t          div_req;
  logic [DIVD_W-1:0] div_dividend;
  logic [DIVS_W-1:0] div_divisor;
  logic              div_done;
  logic [DIVD_W-1:0] div_quo;

  logic [DIVR_W:0]        div_eff;
  logic [DIVD_W-1:0]      tick_ext;
  logic [DIVD_W-1:0]      ms_prod;
  logic                   in_fire;
  logic                   out_free;
  logic                   free_found;
  logic [SLOT_W-1:0]      free_idx;
  logic                   due_any;
  logic [SLOT_W-1:0]      pick_idx;
  logic [ALARM_SLOTS-1:0] due_rest;
  logic [TIME_W:0]        alarm_end;
  logic                   slot_due;
  logic                   scan_last;

  assign in_fire  = in_tvalid && in_tready;
  assign out_free = !out_valid_r || out_tready;
  assign in_tready = (state_r == S_IDLE);

  assign div_eff  = (divider_r == '0) ? {1'b1, {DIVR_W{1'b0}}} : {1'b0, divider_r};
  // tick_count * 1000 as 1024 - 32 + 8
  assign tick_ext = DIVD_W'(tick_cnt_r);
  assign ms_prod  = (tick_ext << 10) - (tick_ext << 5) + (tick_ext << 3);

  always_comb begin
    div_req.start = 1'b0;
    div_req.steps = STEPS_RATE;
    div_dividend  = {BASE_HZ, {(DIVD_W-DIVS_W){1'b0}}};
    div_divisor   = DIVS_W'(div_eff);
    if (state_r == S_IDLE) begin
      div_req.start = in_fire;
    end else if (state_r == S_MUL) begin
      div_req.start = 1'b1;
      div_req.steps = STEPS_TIME;
      div_dividend  = ms_prod;
      div_divisor   = div_quo[DIVS_W-1:0];
    end
  end

  tat_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (div_req),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quo)
  );

  // lowest free slot and lowest due slot
  always_comb begin
    free_idx = '0;
    pick_idx = '0;
    for (int i = ALARM_SLOTS - 1; i >= 0; i--) begin
      if (!slot_valid_r[i]) free_idx = SLOT_W'(i);
      if (due_r[i])         pick_idx = SLOT_W'(i);
    end
    free_found = ~&slot_valid_r;
    due_any    = |due_r;
    due_rest   = due_r;
    due_rest[pick_idx] = 1'b0;
  end

  // 65-bit end so an alarm past 2^64-1 never comes due
  assign alarm_end = {1'b0, rd_start_r} + {1'b0, rd_len_r};
  assign slot_due  = rd_vld_r && !alarm_end[TIME_W] && (alarm_end[TIME_W-1:0] <= time_r);
  assign scan_last = (idx_r == SLOT_W'(ALARM_SLOTS - 1));

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (in_fire) state_nxt = S_RATE;
      S_RATE:  if (div_done) state_nxt = S_MUL;
      S_MUL:   state_nxt = S_TIME;
      S_TIME:  if (div_done) state_nxt = S_SAT;
      S_SAT:   state_nxt = (op_r == OP_SLEEP) ? S_SLEEP : S_RD;
      S_SLEEP: if (out_free) state_nxt = S_IDLE;
      S_RD:    state_nxt = S_CK;
      S_CK:    state_nxt = scan_last ? S_EMIT : S_RD;
      S_EMIT:  if (!due_any) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      divider_r    <= DIV_RESET;
      tick_cnt_r   <= '0;
      slot_valid_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) divider_r <= cfg_wr_data;
      if (in_fire && (in_tuser == OP_TICK)) tick_cnt_r <= tick_cnt_r + 1'b1;
      if (((state_r == S_SLEEP) && out_free) ||
          ((state_r == S_EMIT) && due_any && out_free)) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      if ((state_r == S_SLEEP) && out_free && free_found) slot_valid_r[free_idx] <= 1'b1;
      if ((state_r == S_EMIT) && due_any && out_free) slot_valid_r[pick_idx] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_r   <= in_tuser;
      len_r  <= in_tdata[TIME_W-1:0];
      task_r <= in_tdata[TIME_W+TASK_W-1:TIME_W];
    end
    if (state_r == S_SAT) begin
      time_r <= (div_quo[DIVD_W-1:TIME_W] != '0) ? {TIME_W{1'b1}} : div_quo[TIME_W-1:0];
      idx_r  <= '0;
      due_r  <= '0;
    end
    if (state_r == S_RD) begin
      rd_start_r <= alarm_start[idx_r];
      rd_len_r   <= alarm_len[idx_r];
      rd_vld_r   <= slot_valid_r[idx_r];
    end
    if (state_r == S_CK) begin
      due_r[idx_r] <= slot_due;
      if (!scan_last) idx_r <= idx_r + 1'b1;
    end
    if ((state_r == S_SLEEP) && out_free) begin
      out_status_r <= free_found ? ST_ACCEPT : ST_FULL;
      out_task_r   <= task_r;
      out_time_r   <= time_r;
      out_last_r   <= 1'b1;
      if (free_found) begin
        alarm_start[free_idx] <= time_r;
        alarm_len[free_idx]   <= len_r;
        alarm_task[free_idx]  <= task_r;
      end
    end
    if ((state_r == S_EMIT) && due_any && out_free) begin
      out_status_r <= ST_WOKEN;
      out_task_r   <= alarm_task[pick_idx];
      out_time_r   <= time_r;
      out_last_r   <= (due_rest == '0);
      due_r        <= due_rest;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_time_r, out_task_r};
  assign out_tuser  = out_status_r;
  assign out_tlast  = out_last_r;

endmodule

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top import tat_pkg::*; ();

  localparam int CYCLE_LIMIT = 2000000;
  localparam int TAIL_CYCLES = 300;

  typedef struct {
    logic              op;
    logic [TIME_W-1:0] sleep_len;
    logic [TASK_W-1:0] task_no;
  } alarm_item_t;

  typedef struct {
    status_t           status;
    logic [TASK_W-1:0] task_no;
    logic [TIME_W-1:0] time_ms;
    logic              last;
  } report_t;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     cfg_wr_en = 1'b0;
  logic [DIVR_W-1:0]        cfg_wr_data = '0;
  logic                     in_tvalid = 1'b0;
  logic                     in_tready;
  logic [TIME_W+TASK_W-1:0] in_tdata = '0;   // sleep_ms, task_id
  logic                     in_tuser = 1'b0; // operation
  logic                     out_tvalid;
  logic                     out_tready = 1'b0;
  logic [TASK_W+TIME_W-1:0] out_tdata;       // task_number, time_ms
  logic [1:0]               out_tuser;       // status
  logic                     out_tlast;

  tick_alarm_table_unit DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  // shadow copy of the block state
  logic [DIVR_W-1:0] divider_model;
  logic [TIME_W-1:0] tick_total;
  logic              slot_busy [ALARM_SLOTS];
  logic [TIME_W-1:0] slot_start [ALARM_SLOTS];
  logic [TIME_W-1:0] slot_len [ALARM_SLOTS];
  logic [TASK_W-1:0] slot_task [ALARM_SLOTS];

  alarm_item_t item_q[$];
  report_t     pending_reports[$];
  alarm_item_t cur_item;
  int          items_queued = 0;
  int          beats_taken = 0;
  int          errors = 0;
  int          cycle_count = 0;
  int          feed_gap = 0;
  int          drain_stall = 0;
  bit          feed_idle = 1'b0;
  bit          drain_idle = 1'b0;

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic int rand_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 20);
    return $urandom_range(30, 120);
  endfunction

  // floor(1000 * ticks / floor(base / divider)), saturated to 64 bits
  function automatic logic [TIME_W-1:0] elapsed_ms(logic [TIME_W-1:0] ticks,
                                                   logic [DIVR_W-1:0] div);
    logic [127:0] eff_div;
    logic [127:0] rate;
    logic [127:0] quot;
    eff_div = (div == '0) ? 128'd65536 : {112'd0, div};
    rate    = {107'd0, BASE_HZ} / eff_div;
    quot    = ({64'd0, ticks} * 128'd1000) / rate;
    if (quot[127:64] != '0) return '1;
    return quot[63:0];
  endfunction

  task automatic step_alarm_table(input alarm_item_t it);
    logic [TIME_W-1:0] now_ms;
    logic [TIME_W:0]   due_at;
    report_t           woken [ALARM_SLOTS];
    report_t           rep;
    int                free_slot;
    int                n;
    free_slot = -1;
    n = 0;
    if (it.op == OP_SLEEP) begin
      now_ms = elapsed_ms(tick_total, divider_model);
      for (int i = ALARM_SLOTS - 1; i >= 0; i--) begin
        if (!slot_busy[i]) free_slot = i;
      end
      rep.task_no = it.task_no;
      rep.time_ms = now_ms;
      rep.last    = 1'b1;
      if (free_slot >= 0) begin
        slot_busy[free_slot]  = 1'b1;
        slot_start[free_slot] = now_ms;
        slot_len[free_slot]   = it.sleep_len;
        slot_task[free_slot]  = it.task_no;
        rep.status = ST_ACCEPT;
      end else begin
        rep.status = ST_FULL;
      end
      pending_reports.insert(pending_reports.size(), rep);
    end else begin
      tick_total = tick_total + 1'b1;
      now_ms = elapsed_ms(tick_total, divider_model);
      for (int i = 0; i < ALARM_SLOTS; i++) begin
        // 65-bit end so an alarm past the top of the time range never fires
        due_at = {1'b0, slot_start[i]} + {1'b0, slot_len[i]};
        if (slot_busy[i] && n < 16 && due_at <= {1'b0, now_ms}) begin
          slot_busy[i]     = 1'b0;
          woken[n].status  = ST_WOKEN;
          woken[n].task_no = slot_task[i];
          woken[n].time_ms = now_ms;
          woken[n].last    = 1'b0;
          n++;
        end
      end
      for (int k = 0; k < n; k++) begin
        rep = woken[k];
        rep.last = (k == n - 1);
        pending_reports.insert(pending_reports.size(), rep);
      end
    end
  endtask

  // input side: present queued items, with random gaps between beats when feed_idle is set
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        step_alarm_table(cur_item);
        beats_taken++;
      end
      if (!in_tvalid || in_tready) begin
        if (feed_gap != 0) begin
          feed_gap--;
          in_tvalid <= 1'b0;
        end else if (item_q.size() != 0) begin
          cur_item = item_q.pop_front();
          in_tvalid <= 1'b1;
          in_tuser <= cur_item.op;
          in_tdata <= {cur_item.task_no, cur_item.sleep_len};
          feed_gap = feed_idle ? rand_gap() : 0;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // result side: compare each beat against the oldest prediction; stall out_tready at random when drain_idle is set
  always @(posedge clk) begin : result_check
    report_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_reports.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected beat at cycle %0d: status %0d task %0d time %0d last %0b",
                   cycle_count, out_tuser, out_tdata[TASK_W-1:0],
                   out_tdata[TASK_W+TIME_W-1:TASK_W], out_tlast);
      end else begin
        want = pending_reports.pop_front();
        if (out_tuser != want.status || out_tdata[TASK_W-1:0] != want.task_no ||
            out_tdata[TASK_W+TIME_W-1:TASK_W] != want.time_ms ||
            out_tlast != want.last) begin
          errors++;
          if (errors <= 10)
            $display({"mismatch at cycle %0d: expected status %0d task %0d time %0d last %0b,",
                      " got status %0d task %0d time %0d last %0b"},
                     cycle_count, want.status, want.task_no, want.time_ms, want.last,
                     out_tuser, out_tdata[TASK_W-1:0],
                     out_tdata[TASK_W+TIME_W-1:TASK_W], out_tlast);
        end
      end
    end
    if (drain_stall != 0) begin
      drain_stall--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
      if (drain_idle && $urandom_range(0, 3) == 0) drain_stall = rand_gap();
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic add_sleep(input logic [TIME_W-1:0] len, input logic [TASK_W-1:0] id);
    alarm_item_t it;
    it.op        = OP_SLEEP;
    it.sleep_len = len;
    it.task_no   = id;
    item_q.insert(item_q.size(), it);
    items_queued++;
  endtask

  // the data bits of a tick are ignored, so they carry noise
  task automatic add_tick();
    alarm_item_t it;
    it.op        = OP_TICK;
    it.sleep_len = {$urandom(), $urandom()};
    it.task_no   = $urandom_range(0, 255);
    item_q.insert(item_q.size(), it);
    items_queued++;
  endtask

  // mix of ticks, single sleeps and bursts that may fill the table;
  // sleep lengths cover about ten ticks at the current rate
  task automatic add_random(input int count);
    longint unsigned eff_div;
    longint unsigned span;
    int              burst;
    int              made;
    int unsigned     r;
    eff_div = (divider_model == '0) ? 65536 : divider_model;
    span = (10 * 1000 * eff_div) / 1193182;
    made = 0;
    while (made < count) begin
      r = $urandom_range(0, 99);
      if (r < 8) begin
        burst = $urandom_range(3, 10);
        for (int k = 0; k < burst; k++) begin
          add_sleep(64'($urandom_range(0, int'(span))), 8'($urandom_range(0, 255)));
          made++;
        end
      end else if (r < 35) begin
        add_sleep(64'($urandom_range(0, int'(span))), 8'($urandom_range(0, 255)));
        made++;
      end else begin
        add_tick();
        made++;
      end
    end
  endtask

  task automatic settle();
    while (beats_taken != items_queued || pending_reports.size() != 0) @(posedge clk);
    // a tick that wakes nothing leaves no beat to wait for
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  task automatic write_divider(input logic [DIVR_W-1:0] value);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    divider_model = value;
  endtask

  task automatic run_phase(input int count, input bit with_idle);
    feed_idle  = with_idle;
    drain_idle = with_idle;
    add_random(count);
    settle();
  endtask

  initial begin
    divider_model = DIV_RESET;
    tick_total = '0;
    for (int i = 0; i < ALARM_SLOTS; i++) begin
      slot_busy[i]  = 1'b0;
      slot_start[i] = '0;
      slot_len[i]   = '0;
      slot_task[i]  = '0;
    end
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // directed: quiet tick, zero-length sleep, full table, one tick waking all slots
    feed_idle  = 1'b1;
    drain_idle = 1'b1;
    add_tick();
    add_sleep(64'd0, 8'h00);
    add_tick();
    for (int k = 0; k < ALARM_SLOTS; k++) add_sleep(64'd1, 8'(k * 17));
    add_sleep(64'd1, 8'hA5);
    add_tick();
    // these two never come due: one end overflows, one is simply far away
    add_sleep('1, 8'h5A);
    add_sleep(64'h8000_0000_0000_0000, 8'h80);
    add_tick();
    settle();

    write_divider(16'd1);
    run_phase(60, 1'b0);
    write_divider(DIV_RESET);
    run_phase(90, 1'b1);
    write_divider(16'($urandom_range(1200, 30000)));
    run_phase(80, 1'b1);
    write_divider(16'hFFFF);
    run_phase(80, 1'b1);
    write_divider(16'd0);
    run_phase(80, 1'b1);

    if (pending_reports.size() != 0) errors++;
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

@@ tick_alarm_table_unit.f @@
rtl/core/tat_pkg.sv
rtl/core/tat_div.sv
rtl/core/tick_alarm_table_unit.sv
tb/sv/tb_top.sv
